[design/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define RRM_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[design/rrm_pkg.sv]
// Shared types and codes for the retransmit / reply match block.
// No dependencies.
`timescale 1ns / 1ps

package rrm_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_FIRST_WAIT   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_WAIT_CEILING = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SOFT_MODE    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_REPLY_CODE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_ACK_CODE     = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_ALLOC_CODE   = 3'd6;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_HDR   = 3'd2;
    localparam logic [2:0] OP_ABORT = 3'd3;
    localparam logic [2:0] OP_XERR  = 3'd4;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_SEND    = 3'd1;
    localparam logic [2:0] ACT_DISCARD = 3'd2;
    localparam logic [2:0] ACT_REPLY   = 3'd3;
    localparam logic [2:0] ACT_TIMEOUT = 3'd4;
    localparam logic [2:0] ACT_INTR    = 3'd5;
    localparam logic [2:0] ACT_XERR    = 3'd6;

    localparam logic [1:0] SZ_SHORT = 2'd0;
    localparam logic [1:0] SZ_EXACT = 2'd1;

    typedef struct packed {
        logic [15:0] first_wait;
        logic [15:0] wait_ceiling;
        logic [7:0]  retry_limit;
        logic        soft_mode;
        logic [15:0] reply_code;
        logic [15:0] ack_code;
        logic [15:0] alloc_code;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] req_type;
        logic [7:0]  req_sequence;
        logic [15:0] req_conn;
        logic [1:0]  rx_size_class;
        logic [15:0] rx_type;
        logic [7:0]  rx_sequence;
        logic [15:0] rx_conn;
    } item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [16:0] wait_ticks;
        logic        cap_notice;
        logic        stall_notice;
        logic        recover_notice;
    } res_t;

endpackage

[design/rrm_cfg.sv]
// Configuration register file for the retransmit / reply match block.
// Depends on rrm_pkg.
`timescale 1ns / 1ps

module rrm_cfg
    import rrm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_wait   <= 16'd70;
            cfg_reg.wait_ceiling <= 16'd1000;
            cfg_reg.retry_limit  <= 8'd5;
            cfg_reg.soft_mode    <= 1'b0;
            cfg_reg.reply_code   <= 16'd13107;
            cfg_reg.ack_code     <= 16'd39321;
            cfg_reg.alloc_code   <= 16'd4369;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FIRST_WAIT:   cfg_reg.first_wait   <= cfg_data;
                CFG_WAIT_CEILING: cfg_reg.wait_ceiling <= cfg_data;
                CFG_RETRY_LIMIT:  cfg_reg.retry_limit  <= cfg_data[7:0];
                CFG_SOFT_MODE:    cfg_reg.soft_mode    <= cfg_data[0];
                CFG_REPLY_CODE:   cfg_reg.reply_code   <= cfg_data;
                CFG_ACK_CODE:     cfg_reg.ack_code     <= cfg_data;
                CFG_ALLOC_CODE:   cfg_reg.alloc_code   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/rrm_core.sv]
// Request state and per-item update: retry/backoff, wait clamp, header match.
// Depends on rrm_pkg.
`timescale 1ns / 1ps

module rrm_core
    import rrm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    logic        busy_reg, busy_next;
    logic [15:0] held_type_reg, held_type_next;
    logic [7:0]  held_seq_reg, held_seq_next;
    logic [15:0] held_conn_reg, held_conn_next;
    logic [7:0]  retry_reg, retry_next;
    logic [16:0] cur_wait_reg, cur_wait_next;
    logic [15:0] base_wait_reg, base_wait_next;
    logic [16:0] countdown_reg, countdown_next;
    logic        major_reg, major_next;
    logic        ack_reg, ack_next;

    logic        arm;
    logic [16:0] cand;
    logic [16:0] cnt_step;
    logic [16:0] max17;
    logic        over;
    logic [16:0] cur_dbl;
    logic [15:0] base_dbl;
    logic [2:0]  act;
    logic        stall_ev;
    logic        recover_ev;
    logic        is_match;

    assign max17    = {1'b0, cfg.wait_ceiling};
    assign cur_dbl  = cur_wait_reg[16] ? 17'h1FFFF : {cur_wait_reg[15:0], 1'b0};
    assign base_dbl = base_wait_reg[15] ? 16'hFFFF : {base_wait_reg[14:0], 1'b0};
    assign is_match = (item.rx_size_class != SZ_SHORT) && (item.rx_type == cfg.reply_code)
                      && ((held_type_reg == cfg.alloc_code)
                          || ((item.rx_sequence == held_seq_reg)
                              && (item.rx_conn == held_conn_reg)));

    always_comb
    begin
        busy_next      = busy_reg;
        held_type_next = held_type_reg;
        held_seq_next  = held_seq_reg;
        held_conn_next = held_conn_reg;
        retry_next     = retry_reg;
        base_wait_next = base_wait_reg;
        major_next     = major_reg;
        ack_next       = ack_reg;
        cnt_step       = countdown_reg;
        cand           = cur_wait_reg;
        arm            = 1'b0;
        act            = ACT_NONE;
        stall_ev       = 1'b0;
        recover_ev     = 1'b0;
        case (item.opcode)
            OP_START:
            begin
                held_type_next = item.req_type;
                held_seq_next  = item.req_sequence;
                held_conn_next = item.req_conn;
                busy_next      = 1'b1;
                retry_next     = 8'd0;
                major_next     = 1'b0;
                ack_next       = 1'b0;
                base_wait_next = cfg.first_wait;
                cand           = {1'b0, cfg.first_wait};
                arm            = 1'b1;
                act            = ACT_SEND;
            end
            OP_TICK:
            begin
                if (busy_reg)
                begin
                    if (countdown_reg > 17'd1)
                    begin
                        cnt_step = countdown_reg - 17'd1;
                    end
                    else
                    begin
                        cnt_step = 17'd0;
                        if (retry_reg < cfg.retry_limit)
                        begin
                            retry_next = retry_reg + 8'd1;
                            cand       = cur_dbl;
                            arm        = 1'b1;
                            act        = ACT_SEND;
                        end
                        else if (cfg.soft_mode)
                        begin
                            busy_next = 1'b0;
                            act       = ACT_TIMEOUT;
                        end
                        else
                        begin
                            retry_next     = 8'd1;
                            cand           = {base_wait_reg, 1'b0};
                            base_wait_next = base_dbl;
                            stall_ev       = ~major_reg;
                            major_next     = 1'b1;
                            arm            = 1'b1;
                            act            = ACT_SEND;
                        end
                    end
                end
            end
            OP_HDR:
            begin
                act = ACT_DISCARD;
                if (busy_reg)
                begin
                    if ((item.rx_size_class == SZ_EXACT) && (item.rx_type == cfg.ack_code))
                    begin
                        retry_next = 8'd0;
                        cand       = max17;
                        ack_next   = 1'b1;
                        arm        = 1'b1;
                    end
                    else if (is_match)
                    begin
                        recover_ev = major_reg;
                        busy_next  = 1'b0;
                        act        = ACT_REPLY;
                    end
                    else
                    begin
                        arm = 1'b1;
                    end
                end
            end
            OP_ABORT:
            begin
                if (busy_reg)
                begin
                    busy_next = 1'b0;
                    act       = ACT_INTR;
                end
            end
            OP_XERR:
            begin
                if (busy_reg)
                begin
                    busy_next = 1'b0;
                    act       = ACT_XERR;
                end
            end
            default: ;
        endcase
    end

    // arming clamps to the maximum, then reloads the countdown
    assign over           = arm && (cand > max17);
    assign cur_wait_next  = over ? max17 : cand;
    assign countdown_next = arm ? cur_wait_next : cnt_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            held_type_reg <= '0;
            held_seq_reg  <= '0;
            held_conn_reg <= '0;
            retry_reg     <= '0;
            cur_wait_reg  <= '0;
            base_wait_reg <= '0;
            countdown_reg <= '0;
            major_reg     <= 1'b0;
            ack_reg       <= 1'b0;
        end
        else if (fire)
        begin
            busy_reg      <= busy_next;
            held_type_reg <= held_type_next;
            held_seq_reg  <= held_seq_next;
            held_conn_reg <= held_conn_next;
            retry_reg     <= retry_next;
            cur_wait_reg  <= cur_wait_next;
            base_wait_reg <= base_wait_next;
            countdown_reg <= countdown_next;
            major_reg     <= major_next;
            ack_reg       <= ack_next;
        end
    end

    assign res.action         = act;
    assign res.wait_ticks     = cur_wait_next;
    assign res.cap_notice     = over && !ack_next;
    assign res.stall_notice   = stall_ev;
    assign res.recover_notice = recover_ev;

endmodule

[design/rpc_retransmit_reply_match_top.sv]
// Top level: input register, request core, result register, config registers.
// Depends on rrm_pkg, rrm_cfg, rrm_core and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  opcode, req_*, rx_*
//   out      from block out_valid / out_stall action, wait_ticks, *_notice
//   cfg      to block   cfg_wr_en            cfg_index, cfg_data
//
// One item per cycle while out_stall is low; each result is held in the result register.
// The request core updates state when an item leaves the input register.
// in_stall rises only when both input and result registers hold items and out_stall is high.
// Reset clears handshake and request state and loads the default configuration.
`timescale 1ns / 1ps

module rpc_retransmit_reply_match_top
    import rrm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic [15:0]         req_type,
    input  logic [7:0]          req_sequence,
    input  logic [15:0]         req_conn,
    input  logic [1:0]          rx_size_class,
    input  logic [15:0]         rx_type,
    input  logic [7:0]          rx_sequence,
    input  logic [15:0]         rx_conn,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          action,
    output logic [16:0]         wait_ticks,
    output logic                cap_notice,
    output logic                stall_notice,
    output logic                recover_notice,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

`include "assert_macros.svh"

    cfg_t  cfg;
    item_t item_reg;
    logic  item_valid_reg;
    res_t  res;
    res_t  res_reg;
    logic  res_valid_reg;
    logic  in_take;
    logic  fire;

    assign fire     = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && res_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    rrm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rrm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= in_take || (item_valid_reg && !fire);
            res_valid_reg  <= fire || (res_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode        <= opcode;
            item_reg.req_type      <= req_type;
            item_reg.req_sequence  <= req_sequence;
            item_reg.req_conn      <= req_conn;
            item_reg.rx_size_class <= rx_size_class;
            item_reg.rx_type       <= rx_type;
            item_reg.rx_sequence   <= rx_sequence;
            item_reg.rx_conn       <= rx_conn;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = res_valid_reg;
    assign action         = res_reg.action;
    assign wait_ticks     = res_reg.wait_ticks;
    assign cap_notice     = res_reg.cap_notice;
    assign stall_notice   = res_reg.stall_notice;
    assign recover_notice = res_reg.recover_notice;

    `RRM_ASSERT_ALWAYS(a_stall_needs_full, !in_stall || (item_valid_reg && res_valid_reg),
        "in_stall without both stages full")
    `RRM_ASSERT_NEXT(a_fire_fills_out, fire, res_valid_reg,
        "processed item lost before result register")
    `RRM_ASSERT_ALWAYS(a_recover_is_reply, !(out_valid && recover_notice) || (action == ACT_REPLY),
        "recover notice without reply")
    `RRM_ASSERT_ALWAYS(a_stall_is_send, !(out_valid && stall_notice) || (action == ACT_SEND),
        "not-responding notice without send")

endmodule

[tb/rrm_backoff_checker.sv]
// Scoreboard for rpc_retransmit_reply_match_top: mirrors the retransmit/backoff state,
// predicts one result per accepted item and compares results in order.
// Depends on rrm_pkg.
`timescale 1ns / 1ps

module rrm_backoff_checker
    import rrm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [2:0]          opcode,
    input  logic [15:0]         req_type,
    input  logic [7:0]          req_sequence,
    input  logic [15:0]         req_conn,
    input  logic [1:0]          rx_size_class,
    input  logic [15:0]         rx_type,
    input  logic [7:0]          rx_sequence,
    input  logic [15:0]         rx_conn,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [2:0]          action,
    input  logic [16:0]         wait_ticks,
    input  logic                cap_notice,
    input  logic                stall_notice,
    input  logic                recover_notice,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output int                  mismatches,
    output int                  outstanding
);

    cfg_t        regs;
    logic        req_active;
    logic [15:0] req_type_q;
    logic [7:0]  req_seq_q;
    logic [15:0] req_conn_q;
    logic [7:0]  resend_cnt;
    logic [16:0] armed_wait;
    logic [15:0] base_ticks;
    logic [16:0] ticks_left;
    logic        major_hit;
    logic        ack_hit;
    res_t        expected_results[$];

    function automatic logic [16:0] double_wait(logic [16:0] x);
        logic [17:0] y;
        y = {x, 1'b0};
        return (y > 18'h1FFFF) ? 17'h1FFFF : y[16:0];
    endfunction

    task automatic arm_timer(inout logic cap);
        if (armed_wait > {1'b0, regs.wait_ceiling})
        begin
            if (!ack_hit)
                cap = 1'b1;
            armed_wait = {1'b0, regs.wait_ceiling};
        end
        ticks_left = armed_wait;
    endtask

    task automatic predict_backoff(input item_t it, output res_t r);
        logic       cap;
        logic       stalled;
        logic       recovered;
        logic [2:0] act;
        cap = 1'b0;
        stalled = 1'b0;
        recovered = 1'b0;
        act = ACT_NONE;
        case (it.opcode)
            OP_START:
            begin
                req_type_q = it.req_type;
                req_seq_q = it.req_sequence;
                req_conn_q = it.req_conn;
                req_active = 1'b1;
                resend_cnt = '0;
                major_hit = 1'b0;
                ack_hit = 1'b0;
                base_ticks = regs.first_wait;
                armed_wait = {1'b0, regs.first_wait};
                arm_timer(cap);
                act = ACT_SEND;
            end
            OP_TICK:
            begin
                if (req_active)
                begin
                    if (ticks_left > 17'd1)
                        ticks_left = ticks_left - 17'd1;
                    else
                    begin
                        ticks_left = '0;
                        if (resend_cnt < regs.retry_limit)
                        begin
                            resend_cnt = resend_cnt + 8'd1;
                            armed_wait = double_wait(armed_wait);
                            arm_timer(cap);
                            act = ACT_SEND;
                        end
                        else if (regs.soft_mode)
                        begin
                            req_active = 1'b0;
                            act = ACT_TIMEOUT;
                        end
                        else
                        begin
                            // major timeout: restart from doubled base
                            resend_cnt = 8'd1;
                            armed_wait = {base_ticks, 1'b0};
                            base_ticks = base_ticks[15] ? 16'hFFFF : {base_ticks[14:0], 1'b0};
                            stalled = !major_hit;
                            major_hit = 1'b1;
                            arm_timer(cap);
                            act = ACT_SEND;
                        end
                    end
                end
            end
            OP_HDR:
            begin
                act = ACT_DISCARD;
                if (req_active)
                begin
                    if (it.rx_size_class == SZ_EXACT && it.rx_type == regs.ack_code)
                    begin
                        resend_cnt = '0;
                        armed_wait = {1'b0, regs.wait_ceiling};
                        ack_hit = 1'b1;
                        arm_timer(cap);
                    end
                    else if (it.rx_size_class != SZ_SHORT && it.rx_type == regs.reply_code &&
                             (req_type_q == regs.alloc_code ||
                              (it.rx_sequence == req_seq_q && it.rx_conn == req_conn_q)))
                    begin
                        recovered = major_hit;
                        req_active = 1'b0;
                        act = ACT_REPLY;
                    end
                    else
                        arm_timer(cap);
                end
            end
            OP_ABORT:
            begin
                if (req_active)
                begin
                    req_active = 1'b0;
                    act = ACT_INTR;
                end
            end
            OP_XERR:
            begin
                if (req_active)
                begin
                    req_active = 1'b0;
                    act = ACT_XERR;
                end
            end
            default:
            begin
            end
        endcase
        r.action = act;
        r.wait_ticks = armed_wait;
        r.cap_notice = cap;
        r.stall_notice = stalled;
        r.recover_notice = recovered;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        item_t seen;
        res_t  want;
        res_t  got;
        if (!rst_n)
        begin
            regs.first_wait = 16'd70;
            regs.wait_ceiling = 16'd1000;
            regs.retry_limit = 8'd5;
            regs.soft_mode = 1'b0;
            regs.reply_code = 16'd13107;
            regs.ack_code = 16'd39321;
            regs.alloc_code = 16'd4369;
            req_active = 1'b0;
            req_type_q = '0;
            req_seq_q = '0;
            req_conn_q = '0;
            resend_cnt = '0;
            armed_wait = '0;
            base_ticks = '0;
            ticks_left = '0;
            major_hit = 1'b0;
            ack_hit = 1'b0;
            expected_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FIRST_WAIT:   regs.first_wait = cfg_data;
                    CFG_WAIT_CEILING: regs.wait_ceiling = cfg_data;
                    CFG_RETRY_LIMIT:  regs.retry_limit = cfg_data[7:0];
                    CFG_SOFT_MODE:    regs.soft_mode = cfg_data[0];
                    CFG_REPLY_CODE:   regs.reply_code = cfg_data;
                    CFG_ACK_CODE:     regs.ack_code = cfg_data;
                    CFG_ALLOC_CODE:   regs.alloc_code = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                seen = '{opcode, req_type, req_sequence, req_conn,
                         rx_size_class, rx_type, rx_sequence, rx_conn};
                predict_backoff(seen, want);
                expected_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = '{action, wait_ticks, cap_notice, stall_notice, recover_notice};
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: action %0d, wait_ticks %0d", action, wait_ticks);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("action", want.action, got.action);
                    check_field("wait_ticks", want.wait_ticks, got.wait_ticks);
                    check_field("cap_notice", want.cap_notice, got.cap_notice);
                    check_field("stall_notice", want.stall_notice, got.stall_notice);
                    check_field("recover_notice", want.recover_notice, got.recover_notice);
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

[tb/tb_rpc_retransmit_reply_match_top.sv]
// Testbench top for rpc_retransmit_reply_match_top: clock, reset, register setup and
// request/tick/header stimulus with random idling; verdict from rrm_backoff_checker.
// Depends on rrm_pkg, rrm_backoff_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_rpc_retransmit_reply_match_top;
    import rrm_pkg::*;

    localparam int ItemsPerPhase = 130;
    localparam int Phases        = 10;
    localparam int HoldPhase     = 4;
    localparam int HoldCycles    = 300;
    localparam int DrainCycles   = 8;
    localparam int IdleLimit     = 4000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [2:0]          opcode;
    logic [15:0]         req_type;
    logic [7:0]          req_sequence;
    logic [15:0]         req_conn;
    logic [1:0]          rx_size_class;
    logic [15:0]         rx_type;
    logic [7:0]          rx_sequence;
    logic [15:0]         rx_conn;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          action;
    logic [16:0]         wait_ticks;
    logic                cap_notice;
    logic                stall_notice;
    logic                recover_notice;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    int                  mismatches;
    int                  outstanding;

    bit          tx_gaps = 1'b0;
    bit          rx_gaps = 1'b0;
    int          hold_orders = 0;
    int          holds_done = 0;
    int          quiet_cycles = 0;
    cfg_t        cur_cfg;
    bit          session_open = 1'b0;
    logic [7:0]  open_seq = '0;
    logic [15:0] open_conn = '0;

    rpc_retransmit_reply_match_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .req_type       (req_type),
        .req_sequence   (req_sequence),
        .req_conn       (req_conn),
        .rx_size_class  (rx_size_class),
        .rx_type        (rx_type),
        .rx_sequence    (rx_sequence),
        .rx_conn        (rx_conn),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .action         (action),
        .wait_ticks     (wait_ticks),
        .cap_notice     (cap_notice),
        .stall_notice   (stall_notice),
        .recover_notice (recover_notice),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    rrm_backoff_checker u_score (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IdleLimit)
        begin
            $display("rpc_retransmit_reply_match_top verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: random stall bursts, plus long hold-offs on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_orders)
            begin
                out_stall = 1'b1;
                repeat (HoldCycles) @(negedge clk);
                out_stall = 1'b0;
                holds_done++;
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    function automatic cfg_t make_cfg(logic [15:0] init, logic [15:0] max_w, logic [7:0] retries,
                                      logic fail_on_major, logic [15:0] reply, logic [15:0] ack,
                                      logic [15:0] alloc);
        cfg_t c;
        c.first_wait = init;
        c.wait_ceiling = max_w;
        c.retry_limit = retries;
        c.soft_mode = fail_on_major;
        c.reply_code = reply;
        c.ack_code = ack;
        c.alloc_code = alloc;
        return c;
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.opcode = 3'($urandom_range(0, 7));
        it.req_type = 16'($urandom);
        it.req_sequence = 8'($urandom);
        it.req_conn = 16'($urandom);
        it.rx_size_class = 2'($urandom_range(0, 3));
        it.rx_type = 16'($urandom);
        it.rx_sequence = 8'($urandom);
        it.rx_conn = 16'($urandom);
        return it;
    endfunction

    function automatic item_t op_item(logic [2:0] op);
        item_t it;
        it = noise_item();
        it.opcode = op;
        return it;
    endfunction

    function automatic item_t start_item(logic [15:0] t, logic [7:0] s, logic [15:0] c);
        item_t it;
        it = op_item(OP_START);
        it.req_type = t;
        it.req_sequence = s;
        it.req_conn = c;
        return it;
    endfunction

    function automatic item_t hdr_item(logic [1:0] sz, logic [15:0] t, logic [7:0] s,
                                       logic [15:0] c);
        item_t it;
        it = op_item(OP_HDR);
        it.rx_size_class = sz;
        it.rx_type = t;
        it.rx_sequence = s;
        it.rx_conn = c;
        return it;
    endfunction

    // mostly well-formed request exchanges, with near misses and noise mixed in
    function automatic item_t session_item();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (!session_open && $urandom_range(0, 4) != 0)
            pick = 0;
        if (pick < 6)
        begin
            it = start_item(16'($urandom), 8'($urandom), 16'($urandom));
            if ($urandom_range(0, 4) == 0)
                it.req_type = cur_cfg.alloc_code;
            open_seq = it.req_sequence;
            open_conn = it.req_conn;
            session_open = 1'b1;
        end
        else if (pick < 62)
            it = op_item(OP_TICK);
        else if (pick < 70)
            it = hdr_item(SZ_EXACT, cur_cfg.ack_code, 8'($urandom), 16'($urandom));
        else if (pick < 76)
        begin
            it = hdr_item(2'($urandom_range(1, 3)), cur_cfg.reply_code, open_seq, open_conn);
            session_open = 1'b0;
        end
        else if (pick < 86)
        begin
            it = hdr_item(2'($urandom_range(1, 3)), cur_cfg.reply_code, open_seq, open_conn);
            case ($urandom_range(0, 3))
                0: it.rx_size_class = SZ_SHORT;
                1: it.rx_sequence = open_seq ^ 8'(1 << $urandom_range(0, 7));
                2: it.rx_conn = open_conn ^ 16'(1 << $urandom_range(0, 15));
                default: it = op_item(OP_HDR);
            endcase
        end
        else if (pick < 89)
        begin
            it = op_item(OP_ABORT);
            session_open = 1'b0;
        end
        else if (pick < 91)
        begin
            it = op_item(OP_XERR);
            session_open = 1'b0;
        end
        else if (pick < 94)
            it = op_item(3'($urandom_range(5, 7)));
        else
            it = op_item(OP_TICK);
        return it;
    endfunction

    task automatic push_item(input item_t it);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        opcode = it.opcode;
        req_type = it.req_type;
        req_sequence = it.req_sequence;
        req_conn = it.req_conn;
        rx_size_class = it.rx_size_class;
        rx_type = it.rx_type;
        rx_sequence = it.rx_sequence;
        rx_conn = it.rx_conn;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_settings(input cfg_t c);
        settle();
        write_reg(CFG_FIRST_WAIT, c.first_wait);
        write_reg(CFG_WAIT_CEILING, c.wait_ceiling);
        write_reg(CFG_RETRY_LIMIT, {8'd0, c.retry_limit});
        write_reg(CFG_SOFT_MODE, {15'd0, c.soft_mode});
        write_reg(CFG_REPLY_CODE, c.reply_code);
        write_reg(CFG_ACK_CODE, c.ack_code);
        write_reg(CFG_ALLOC_CODE, c.alloc_code);
        cur_cfg = c;
    endtask

    function automatic cfg_t phase_settings(int p);
        case (p)
            0: return make_cfg(16'd1, 16'd3, 8'd0, 1'b0, 16'h0000, 16'hFFFF, 16'h0000);
            1: return make_cfg(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
            2: return make_cfg(16'd40, 16'd1, 8'd1, 1'b0, 16'h5A5A, 16'h5A5A, 16'($urandom));
            default:
                return make_cfg(16'($urandom_range(1, 6)), 16'($urandom_range(1, 30)),
                                8'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
                                16'($urandom), 16'($urandom), 16'($urandom));
        endcase
    endfunction

    initial
    begin : stimulus
        item_t it;
        int    n;
        bit    counts;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_TICK;
        req_type = '0;
        req_sequence = '0;
        req_conn = '0;
        rx_size_class = '0;
        rx_type = '0;
        rx_sequence = '0;
        rx_conn = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_cfg = make_cfg(16'd70, 16'd1000, 8'd5, 1'b0, 16'd13107, 16'd39321, 16'd4369);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // reset configuration; idle behavior first
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        push_item(op_item(OP_TICK));
        push_item(op_item(OP_HDR));
        push_item(op_item(OP_ABORT));
        push_item(op_item(OP_XERR));
        push_item(op_item(3'd7));
        push_item(start_item(16'hFFFF, 8'hFF, 16'hFFFF));
        push_item(hdr_item(SZ_EXACT, 16'd39321, 8'h00, 16'h0000));
        push_item(hdr_item(2'd2, 16'd13107, 8'hFF, 16'hFFFF));

        load_settings(make_cfg(16'd1, 16'd4, 8'd1, 1'b0, 16'h3333, 16'h9999, 16'h1111));
        push_item(start_item(16'h0000, 8'h00, 16'h0000));
        push_item(start_item(16'h1234, 8'h5A, 16'hA5A5));
        push_item(op_item(OP_TICK));
        push_item(op_item(OP_TICK));
        push_item(op_item(OP_TICK));
        push_item(hdr_item(SZ_SHORT, 16'h3333, 8'h5A, 16'hA5A5));
        push_item(hdr_item(SZ_EXACT, 16'h3333, 8'h5B, 16'hA5A5));
        push_item(hdr_item(SZ_EXACT, 16'h9999, 8'h00, 16'h0000));
        push_item(hdr_item(2'd3, 16'h3333, 8'h5A, 16'hA5A5));
        push_item(start_item(16'h1111, 8'h01, 16'h0001));
        push_item(hdr_item(2'd2, 16'h3333, 8'($urandom), 16'($urandom)));
        push_item(start_item(16'h0F0F, 8'h10, 16'h2020));
        push_item(op_item(OP_ABORT));
        push_item(start_item(16'hF0F0, 8'h20, 16'h4040));
        push_item(op_item(OP_XERR));

        // first wait above the maximum, then a soft-mode timeout
        load_settings(make_cfg(16'd9, 16'd4, 8'd0, 1'b1, 16'h3333, 16'h9999, 16'h1111));
        push_item(start_item(16'h0001, 8'h02, 16'h0003));
        repeat (5) push_item(op_item(OP_TICK));

        for (int p = 0; p < Phases; p++)
        begin
            load_settings(phase_settings(p));
            tx_gaps = (p < Phases - 1) && ($urandom_range(0, 3) != 0);
            rx_gaps = (p < Phases - 1) && ($urandom_range(0, 3) != 0);
            if (p == HoldPhase)
                hold_orders = hold_orders + 1;
            n = 0;
            while (n < ItemsPerPhase)
            begin
                counts = session_open;
                it = session_item();
                if (it.opcode == OP_START)
                    counts = 1'b1;
                if (it.opcode > OP_XERR)
                    counts = 1'b0;
                push_item(it);
                if (counts)
                    n++;
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("rpc_retransmit_reply_match_top verification clean");
        else
            $display("rpc_retransmit_reply_match_top verification failed");
        $finish;
    end

endmodule
